>>> rtl/mrrc_pkg.sv
// Shared types, constants and the CRC byte step for the Modbus RTU reply checker.
// No dependencies; imported by modbus_rtu_reply_checker and its testbench.
`timescale 1ns / 1ps

package mrrc_pkg;

	typedef enum logic [1:0] {
		KIND_START  = 2'd0,
		KIND_STOP   = 2'd1,
		KIND_STATUS = 2'd2,
		KIND_SPEED  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_HEADER = 2'd1,
		ERR_LENGTH = 2'd2,
		ERR_CRC    = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		REG_DEV_ADDR = 2'd0,
		REG_RD_FUNC  = 2'd1,
		REG_WR_FUNC  = 2'd2
	} cfg_reg_t;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [7:0]  DEV_ADDR_RST = 8'h01;
	localparam logic [7:0]  RD_FUNC_RST  = 8'h04;
	localparam logic [7:0]  WR_FUNC_RST  = 8'h05;
	localparam logic [5:0]  STATUS_LEN = 6'd19;
	localparam logic [5:0]  SPEED_LEN  = 6'd7;
	localparam logic [5:0]  COUNT_MAX  = 6'd63;

	// byte positions at which a big-endian word completes (low byte position)
	localparam logic [5:0]  POS_HDR    = 6'd1;
	localparam logic [5:0]  POS_W3     = 6'd4;
	localparam logic [5:0]  POS_W5     = 6'd6;
	localparam logic [5:0]  POS_W7     = 6'd8;
	localparam logic [5:0]  POS_W11    = 6'd12;
	localparam logic [5:0]  POS_W13    = 6'd14;
	localparam logic [5:0]  POS_W15    = 6'd16;

	localparam int unsigned OUT_W = 120;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

>>> rtl/modbus_rtu_reply_checker.sv
// Modbus RTU reply checker: byte stream in, one verdict beat per frame out.
// Depends on mrrc_pkg (kinds, error codes, CRC step).
`timescale 1ns / 1ps
//
// Channel   Dir  Beat                  Fields (low bit up)
// s_axis    in   one reply byte        tdata: data_byte; tlast: last_byte;
//                                      tuser: expected_kind
// m_axis    out  one verdict per frame tdata: frame_ok, error_code, reply_kind,
//                                      temp_first .. sensor_state, motor_speed
// cfg       in   register write        cfg_index selects, cfg_data is the value
//
// One byte per cycle sustained. Accept cycle: count, CRC (eight bit steps) and
// store write, plus a read of the previous byte; the next cycle joins the two into
// a word and, on the last byte, loads the verdict register once it is free.
// Verdicts pass stage 1, then the output register. Input stalls only while a
// verdict waits in the output register and a last byte sits in the second stage.
// Reset presets count, CRC, cfg registers and valids; frame store needs no clearing.

module modbus_rtu_reply_checker
	import mrrc_pkg::*;
#(
	parameter int unsigned MAX_FRAME = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // [7:0] data_byte
	input  logic                 s_axis_tlast,  // last_byte
	input  logic [1:0]           s_axis_tuser,  // [1:0] expected_kind
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [OUT_W-1:0]     m_axis_tdata,  // frame_ok, error_code[2:1], reply_kind[4:3],
	                                            // temp_first[20:5], temp_second[36:21],
	                                            // temp_cold_head[52:37], status_upper[68:53],
	                                            // status_lower[84:69], sensor_state[100:85],
	                                            // motor_speed[116:101], zero pad
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data
);

	localparam int unsigned AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;

	logic [7:0]  mem [MAX_FRAME];

	logic [7:0]  dev_addr_q, rd_func_q, wr_func_q;
	logic [5:0]  cnt_q;
	logic [15:0] crc_q;

	logic        vld_s1, last_s1;
	logic [7:0]  byte_s1, rd_s1;
	kind_t       kind_s1;
	logic [5:0]  pos_s1, n_s1;
	logic [15:0] crc_s1;

	logic [15:0] hdr_q, w3_q, w5_q, w7_q, w11_q, w13_q, w15_q;

	logic        out_vld_q;
	logic [OUT_W-1:0] out_q;

	logic        in_fire, out_free, s1_go, s1_emit, mem_we;
	logic [15:0] crc_nxt, word_s1, hdr_now;
	logic [5:0]  cnt_inc;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0]  func_exp;
	err_t        err;
	logic        ok, st_ok, sp_ok;
	logic [OUT_W-1:0] out_d;

	assign out_free      = !out_vld_q || m_axis_tready;
	assign s1_go         = !last_s1 || out_free;
	assign s_axis_tready = !vld_s1 || s1_go;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign s1_emit       = vld_s1 && last_s1 && out_free;

	assign crc_nxt = crc_feed(crc_q, s_axis_tdata);
	assign cnt_inc = (cnt_q < COUNT_MAX) ? cnt_q + 6'd1 : cnt_q;
	assign mem_we  = in_fire && (32'(cnt_q) < MAX_FRAME);
	assign wr_addr = AW'(cnt_q);
	assign rd_addr = AW'(cnt_q - 6'd1);

	// frame store: byte written at its position, previous byte read in the same beat
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= s_axis_tdata;
		if (in_fire)
			rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RST;
			rd_func_q  <= RD_FUNC_RST;
			wr_func_q  <= WR_FUNC_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEV_ADDR: dev_addr_q <= cfg_data;
				REG_RD_FUNC:  rd_func_q  <= cfg_data;
				REG_WR_FUNC:  wr_func_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame state and stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			crc_q  <= CRC_INIT;
			vld_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			if (in_fire) begin
				cnt_q <= s_axis_tlast ? 6'd0 : cnt_inc;
				crc_q <= s_axis_tlast ? CRC_INIT : crc_nxt;
				vld_s1 <= 1'b1;
				last_s1 <= s_axis_tlast;
			end else if (s1_go) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= s_axis_tdata;
			kind_s1 <= kind_t'(s_axis_tuser);
			pos_s1  <= cnt_q;
			n_s1    <= cnt_inc;
			crc_s1  <= crc_nxt;
		end
	end

	assign word_s1 = {rd_s1, byte_s1};

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			case (pos_s1)
				POS_HDR: hdr_q <= word_s1;
				POS_W3:  w3_q  <= word_s1;
				POS_W5:  w5_q  <= word_s1;
				POS_W7:  w7_q  <= word_s1;
				POS_W11: w11_q <= word_s1;
				POS_W13: w13_q <= word_s1;
				POS_W15: w15_q <= word_s1;
				default: ;
			endcase
		end
	end

	// a two-byte frame completes its header in this very beat
	assign hdr_now  = (pos_s1 == POS_HDR) ? word_s1 : hdr_q;
	assign func_exp = (kind_s1 == KIND_STATUS || kind_s1 == KIND_SPEED) ? rd_func_q : wr_func_q;

	always_comb begin
		if (n_s1 < 6'd2 || hdr_now[15:8] != dev_addr_q || hdr_now[7:0] != func_exp)
			err = ERR_HEADER;
		else if (kind_s1 == KIND_STATUS && n_s1 != STATUS_LEN)
			err = ERR_LENGTH;
		else if (kind_s1 == KIND_SPEED && n_s1 != SPEED_LEN)
			err = ERR_LENGTH;
		else if ((kind_s1 == KIND_STATUS || kind_s1 == KIND_SPEED) && crc_s1 != 16'h0000)
			err = ERR_CRC;
		else
			err = ERR_NONE;
	end

	assign ok    = (err == ERR_NONE);
	assign st_ok = ok && kind_s1 == KIND_STATUS;
	assign sp_ok = ok && kind_s1 == KIND_SPEED;

	always_comb begin
		out_d          = '0;
		out_d[0]       = ok;
		out_d[2:1]     = err;
		out_d[4:3]     = kind_s1;
		out_d[20:5]    = st_ok ? w3_q  : 16'h0000;
		out_d[36:21]   = st_ok ? w5_q  : 16'h0000;
		out_d[52:37]   = st_ok ? w7_q  : 16'h0000;
		out_d[68:53]   = st_ok ? w11_q : 16'h0000;
		out_d[84:69]   = st_ok ? w13_q : 16'h0000;
		out_d[100:85]  = st_ok ? w15_q : 16'h0000;
		out_d[116:101] = sp_ok ? w3_q  : 16'h0000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (s1_emit)
			out_vld_q <= 1'b1;
		else if (m_axis_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_emit)
			out_q <= out_d;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

endmodule

>>> tb/sv/modbus_rtu_reply_checker_tb.sv
// Self-checking bench for modbus_rtu_reply_checker: reply frames in, verdict beats checked
// against a byte-level model of count, CRC-16 and captured bytes kept in this file.
// Depends on mrrc_pkg (kinds, error codes, register indexes) and the RTL top.
`timescale 1ns / 1ps

module modbus_rtu_reply_checker_tb;
	import mrrc_pkg::*;

	localparam int STORE_DEPTH   = 32;
	localparam int SETTLE_CYCLES = 6;
	localparam int LONG_HOLD     = 300;
	localparam int HOLD_AFTER    = 12;
	localparam int PAUSE_AT      = 15;

	// same bit order as m_axis_tdata, ok in bit 0
	typedef struct packed {
		logic [15:0] motor_speed;
		logic [15:0] sensor_state;
		logic [15:0] status_lower;
		logic [15:0] status_upper;
		logic [15:0] temp_cold_head;
		logic [15:0] temp_second;
		logic [15:0] temp_first;
		kind_t       kind;
		err_t        err;
		logic        ok;
	} verdict_t;

	typedef struct {
		kind_t      kind;
		int         len;
		bit         bad_hdr;
		bit         bad_crc;
		logic [7:0] fill;
		err_t       verdict;
	} probe_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	// model of the block's registers and frame state
	logic [7:0] want_addr, want_rd_func, want_wr_func;
	logic [5:0] frame_len;
	logic [15:0] frame_crc;
	logic [7:0] frame_bytes [STORE_DEPTH];

	verdict_t verdicts_due [$];
	logic [7:0] reply_bytes [$];
	verdict_t due, seen;
	int failures = 0;
	bit calm = 1'b0;
	probe_row_t probes [6];

	modbus_rtu_reply_checker #(.MAX_FRAME(STORE_DEPTH)) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata (s_tdata),
		.s_axis_tlast (s_tlast),
		.s_axis_tuser (s_tuser),
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata (m_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2ms;
		$display("modbus_rtu_reply_checker_tb NOT OK");
		$finish;
	end

	// serial form: one feedback bit per data bit, LSB first
	function automatic logic [15:0] crc16_shift(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	function automatic logic [15:0] stored_word(input int hi);
		return {frame_bytes[hi], frame_bytes[hi + 1]};
	endfunction

	function automatic logic [7:0] func_for(input kind_t k);
		return (k == KIND_STATUS || k == KIND_SPEED) ? want_rd_func : want_wr_func;
	endfunction

	task automatic absorb_byte(input logic [7:0] b, input bit last, input kind_t k,
			output bit produced, output verdict_t v);
		err_t e;
		if (frame_len < STORE_DEPTH)
			frame_bytes[frame_len] = b;
		frame_crc = crc16_shift(frame_crc, b);
		if (frame_len != COUNT_MAX)
			frame_len = frame_len + 6'd1;
		v = '0;
		produced = last;
		if (!last)
			return;
		if (frame_len < 2 || frame_bytes[0] != want_addr || frame_bytes[1] != func_for(k))
			e = ERR_HEADER;
		else if (k == KIND_STATUS && frame_len != STATUS_LEN)
			e = ERR_LENGTH;
		else if (k == KIND_SPEED && frame_len != SPEED_LEN)
			e = ERR_LENGTH;
		else if ((k == KIND_STATUS || k == KIND_SPEED) && frame_crc != 16'h0000)
			e = ERR_CRC;
		else
			e = ERR_NONE;
		v.ok = (e == ERR_NONE);
		v.err = e;
		v.kind = k;
		if (e == ERR_NONE && k == KIND_STATUS) begin
			v.temp_first     = stored_word(3);
			v.temp_second    = stored_word(5);
			v.temp_cold_head = stored_word(7);
			v.status_upper   = stored_word(11);
			v.status_lower   = stored_word(13);
			v.sensor_state   = stored_word(15);
		end else if (e == ERR_NONE && k == KIND_SPEED) begin
			v.motor_speed = stored_word(3);
		end
		frame_len = '0;
		frame_crc = CRC_INIT;
	endtask

	// header from the current registers, body, optional CRC trailer (low byte first)
	task automatic compose_reply(input kind_t k, input int len, input bit bad_hdr,
			input bit bad_crc, input bit with_crc, input bit rand_body, input logic [7:0] fill);
		logic [15:0] c;
		int body;
		int pos;
		reply_bytes.delete();
		body = (with_crc && len >= 4) ? len - 2 : len;
		for (int i = 0; i < body; i++) begin
			if (i == 0)
				reply_bytes.push_back(want_addr);
			else if (i == 1)
				reply_bytes.push_back(func_for(k));
			else if (rand_body)
				reply_bytes.push_back(8'($urandom));
			else
				reply_bytes.push_back(i[0] ? fill : ~fill);
		end
		if (body != len) begin
			c = CRC_INIT;
			foreach (reply_bytes[j])
				c = crc16_shift(c, reply_bytes[j]);
			reply_bytes.push_back(c[7:0]);
			reply_bytes.push_back(c[15:8]);
		end
		if (bad_hdr && len >= 2) begin
			pos = $urandom_range(0, 1);
			reply_bytes[pos] = reply_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
		end
		// single bit flip past the header always breaks the residue
		if (bad_crc && len >= 4) begin
			pos = $urandom_range(2, len - 1);
			reply_bytes[pos] = reply_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input bit last, input kind_t k);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		s_tuser <= k;
		do @(posedge clk); while (s_tready !== 1'b1);
	endtask

	// kind only counts on the last beat, so the others carry a random one
	task automatic send_reply(input kind_t k, input bit typed, input err_t typed_err);
		bit produced;
		bit last;
		kind_t beat_kind;
		verdict_t v;
		foreach (reply_bytes[j]) begin
			last = (j == reply_bytes.size() - 1);
			beat_kind = last ? k : kind_t'(2'($urandom_range(0, 3)));
			send_byte(reply_bytes[j], last, beat_kind);
			absorb_byte(reply_bytes[j], last, beat_kind, produced, v);
			if (produced) begin
				if (typed) begin
					v.ok = (typed_err == ERR_NONE);
					v.err = typed_err;
				end
				verdicts_due.push_back(v);
			end
		end
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DEV_ADDR: want_addr = val;
			REG_RD_FUNC:  want_rd_func = val;
			REG_WR_FUNC:  want_wr_func = val;
			default: ;
		endcase
	endtask

	task automatic load_registers(input logic [7:0] a, input logic [7:0] rd, input logic [7:0] wr);
		write_reg(REG_DEV_ADDR, a);
		write_reg(REG_RD_FUNC, rd);
		write_reg(REG_WR_FUNC, wr);
	endtask

	// mostly well-formed replies with random content, the rest broken or noise
	task automatic run_traffic(input int n_bytes);
		int sent;
		int frames;
		int r;
		int len;
		kind_t k;
		bit bad_hdr, bad_crc, with_crc;
		sent = 0;
		frames = 0;
		while (sent < n_bytes) begin
			if (frames == PAUSE_AT)
				settle();
			k = kind_t'(2'($urandom_range(0, 3)));
			r = $urandom_range(0, 99);
			calm = ($urandom_range(0, 3) == 0);
			len = (k == KIND_STATUS) ? int'(STATUS_LEN) :
				(k == KIND_SPEED) ? int'(SPEED_LEN) : $urandom_range(2, 8);
			with_crc = (k == KIND_STATUS || k == KIND_SPEED) || $urandom_range(0, 1);
			bad_hdr = (r < 10);
			bad_crc = (r >= 10 && r < 20);
			if (r >= 20 && r < 28)
				len = $urandom_range(1, 24);
			else if (r >= 28 && r < 32)
				len = $urandom_range(56, 70);   // saturates the count past 63
			compose_reply(k, len, bad_hdr, bad_crc, with_crc, 1'b1, 8'h00);
			if (r >= 32 && r < 36)
				foreach (reply_bytes[j])
					reply_bytes[j] = 8'($urandom);
			send_reply(k, 1'b0, ERR_NONE);
			sent += reply_bytes.size();
			frames++;
		end
		calm = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (verdicts_due.size() == 0) begin
				$error("verdict beat with no verdict pending");
				failures++;
			end else begin
				due = verdicts_due.pop_front();
				seen = m_tdata[116:0];
				check_field("frame_ok", 16'(due.ok), 16'(seen.ok));
				check_field("error_code", 16'(due.err), 16'(seen.err));
				check_field("reply_kind", 16'(due.kind), 16'(seen.kind));
				check_field("temp_first", due.temp_first, seen.temp_first);
				check_field("temp_second", due.temp_second, seen.temp_second);
				check_field("temp_cold_head", due.temp_cold_head, seen.temp_cold_head);
				check_field("status_upper", due.status_upper, seen.status_upper);
				check_field("status_lower", due.status_lower, seen.status_lower);
				check_field("sensor_state", due.sensor_state, seen.sensor_state);
				check_field("motor_speed", due.motor_speed, seen.motor_speed);
				check_field("pad", 16'h0000, 16'(m_tdata[OUT_W-1:117]));
			end
		end
	end

	// verdict side: random stalls, plus one long hold-off so the block backs up
	initial begin : verdict_sink
		int gap;
		int taken;
		taken = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken == HOLD_AFTER)
				gap = LONG_HOLD;
			else
				gap = calm ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			taken++;
		end
	end

	initial begin
		want_addr = DEV_ADDR_RST;
		want_rd_func = RD_FUNC_RST;
		want_wr_func = WR_FUNC_RST;
		frame_len = '0;
		frame_crc = CRC_INIT;
		probes = '{
			'{KIND_START,  2, 1'b0, 1'b0, 8'h00, ERR_NONE},
			'{KIND_STOP,   1, 1'b0, 1'b0, 8'h00, ERR_HEADER},   // short header
			'{KIND_STOP,   4, 1'b1, 1'b0, 8'hFF, ERR_HEADER},
			'{KIND_SPEED,  7, 1'b0, 1'b0, 8'hFF, ERR_NONE},
			'{KIND_SPEED,  7, 1'b0, 1'b1, 8'h5A, ERR_CRC},
			'{KIND_STATUS, 4, 1'b0, 1'b0, 8'hA5, ERR_LENGTH}    // good CRC, too short
		};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (probes[p]) begin
			compose_reply(probes[p].kind, probes[p].len, probes[p].bad_hdr, probes[p].bad_crc,
				1'b1, 1'b0, probes[p].fill);
			send_reply(probes[p].kind, 1'b1, probes[p].verdict);
		end
		run_traffic(180);
		settle();
		load_registers(8'h00, 8'h00, 8'h00);
		run_traffic(150);
		settle();
		load_registers(8'hFF, 8'hFF, 8'hFF);
		run_traffic(150);
		settle();
		load_registers(8'($urandom), 8'($urandom), 8'($urandom));
		run_traffic(200);
		settle();

		if (failures == 0)
			$display("modbus_rtu_reply_checker_tb OK");
		else
			$display("modbus_rtu_reply_checker_tb NOT OK");
		$finish;
	end

endmodule
